@@ rtl/nearest_tet_barycentric_weights_assert.svh @@
// Assertion macros for the checker file.
`ifndef NEAREST_TET_BARYCENTRIC_WEIGHTS_ASSERT_SVH
`define NEAREST_TET_BARYCENTRIC_WEIGHTS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define NTBW_ASSERT_IMPL(name, ante, cons) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("ntbw check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define NTBW_ASSERT_NEXT(name, ante, cons) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("ntbw check failed");

`endif

@@ rtl/ntbw_pkg.sv @@
package ntbw_pkg;

	localparam int COORD_BITS = 20;
	localparam int ID_BITS    = 10;
	localparam int CNT_BITS   = 11;
	localparam int W_BITS     = 18;
	localparam int VOL_BITS   = 64;
	localparam int MAX_VERTS  = 1024;
	localparam int MAX_TETS   = 1024;
	localparam int VERT_W     = 3 * COORD_BITS;
	localparam int TET_W      = 4 * ID_BITS;
	localparam int FRAC_BITS  = 16;
	localparam int DIV_STEPS  = VOL_BITS + FRAC_BITS;
	localparam int STEP_BITS  = $clog2(DIV_STEPS + 1);
	localparam int NUM_CELLS  = 4;

	// command codes
	localparam logic [1:0] FUNC_LOAD_VERT = 2'd0;
	localparam logic [1:0] FUNC_LOAD_TET  = 2'd1;
	localparam logic [1:0] FUNC_QUERY     = 2'd2;

	// Q2.16 limits
	localparam logic [W_BITS-1:0] W_POS_MAX   = 18'h1FFFF;
	localparam logic [W_BITS-1:0] W_NEG_LIMIT = 18'h20000;
	localparam logic [W_BITS-1:0] W_Q_CAP     = 18'h20001;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [ID_BITS-1:0]           id_t;
	typedef logic signed [VOL_BITS-1:0]   vol_t;
	typedef logic signed [W_BITS-1:0]     weight_t;

	// handed from one divider cell to the next every cycle
	typedef struct packed {
		logic start;
		vol_t divisor;
	} div_link_t;

endpackage

@@ rtl/ntbw_cmd_if.sv @@
interface ntbw_cmd_if import ntbw_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] func;
	id_t        slot;
	coord_t     coord_x;
	coord_t     coord_y;
	coord_t     coord_z;
	id_t        corner_in_a;
	id_t        corner_in_b;
	id_t        corner_in_c;
	id_t        corner_in_d;

	modport source (output valid, func, slot, coord_x, coord_y, coord_z,
		corner_in_a, corner_in_b, corner_in_c, corner_in_d, input ready);
	modport sink (input valid, func, slot, coord_x, coord_y, coord_z,
		corner_in_a, corner_in_b, corner_in_c, corner_in_d, output ready);
endinterface

@@ rtl/ntbw_rsp_if.sv @@
interface ntbw_rsp_if import ntbw_pkg::*; ();
	logic    valid;
	logic    ready;
	id_t     corner_a;
	id_t     corner_b;
	id_t     corner_c;
	id_t     corner_d;
	weight_t weight_a;
	weight_t weight_b;
	weight_t weight_c;
	weight_t weight_d;
	logic    degenerate;

	modport source (output valid, corner_a, corner_b, corner_c, corner_d,
		weight_a, weight_b, weight_c, weight_d, degenerate, input ready);
	modport sink (input valid, corner_a, corner_b, corner_c, corner_d,
		weight_a, weight_b, weight_c, weight_d, degenerate, output ready);
endinterface

@@ rtl/ntbw_ram.sv @@
module ntbw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/ntbw_div_cell.sv @@
// One restoring divider: |numer| * 2^16 / divisor, one quotient bit a cycle,
// quotient clamped as it grows. Start and divisor ripple to the next cell.
module ntbw_div_cell import ntbw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_link_t link_in,
	input  vol_t      numer,
	output div_link_t link_out,
	output logic      done,
	output weight_t   weight
);
	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] cnt_q;
	div_link_t            link_q;
	logic [DIV_STEPS-1:0] num_q;
	logic [VOL_BITS-1:0]  rem_q;
	logic [VOL_BITS-1:0]  dvsr_q;
	logic [W_BITS-1:0]    quo_q;
	logic                 neg_q;

	logic [VOL_BITS-1:0] mag;
	logic [VOL_BITS-1:0] rem_sh;
	logic                ge;
	logic [VOL_BITS-1:0] rem_nx;
	logic [W_BITS:0]     quo_sh;
	logic [W_BITS-1:0]   quo_nx;

	always_comb begin
		mag    = numer[VOL_BITS-1] ? (VOL_BITS'(0) - numer) : numer;
		rem_sh = {rem_q[VOL_BITS-2:0], num_q[DIV_STEPS-1]};
		ge     = (rem_sh >= dvsr_q);
		rem_nx = ge ? (rem_sh - dvsr_q) : rem_sh;
		quo_sh = {quo_q, ge};
		quo_nx = (quo_sh > {1'b0, W_NEG_LIMIT}) ? W_Q_CAP : quo_sh[W_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			link_q <= '0;
		end else begin
			link_q <= link_in;
			done_q <= busy_q && (cnt_q == STEP_BITS'(1));
			if (link_in.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_BITS'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_BITS'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (link_in.start) begin
			neg_q  <= numer[VOL_BITS-1];
			num_q  <= {mag, {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			quo_q  <= '0;
			dvsr_q <= link_in.divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_STEPS-2:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	always_comb begin
		if (neg_q) begin
			weight = (quo_q >= W_NEG_LIMIT) ? W_NEG_LIMIT : (W_BITS'(0) - quo_q);
		end else begin
			weight = (quo_q > W_POS_MAX) ? W_POS_MAX : quo_q;
		end
	end

	assign link_out = link_q;
	assign done     = done_q;
endmodule

@@ rtl/nearest_tet_barycentric_weights.sv @@
// Nearest-tetrahedron barycentric weights. Words on cmd either load a vertex
// (func 0, x/y/z Q12.8 into slot), load a tetrahedron (func 1, four vertex
// ids into slot) or query a point (func 2); loads give no rsp word, a query
// gives exactly one. A query scans tetrahedra 0..tet_count-1 (0 acts as 1,
// values above 1024 as 1024) one per cycle out of the tet table, keeps the
// one whose centroid is nearest (earliest on a tie), rereads it, forms four
// volumes one after another on a shared multiply pipeline and divides in a
// row of four divider cells, whose start and divisor ripple from cell to
// cell. The tet table read port paces the scan and the 80-step divider row
// the tail. Weights are Q2.16 truncated toward zero and saturated; a
// reference volume of zero or less sets degenerate with zero weights. cmd is
// taken only when no query is in flight; a finished word waits in the rsp
// register without holding off the next cmd. Tables are not cleared;
// reading a never-written entry gives unspecified data.
module nearest_tet_barycentric_weights import ntbw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CNT_BITS-1:0] cfg_wdata,
	ntbw_cmd_if.sink            cmd,
	ntbw_rsp_if.source          rsp
);
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SCAN   = 4'd1;
	localparam logic [3:0] ST_DRAIN  = 4'd2;
	localparam logic [3:0] ST_FETCH0 = 4'd3;
	localparam logic [3:0] ST_FETCH1 = 4'd4;
	localparam logic [3:0] ST_FETCH2 = 4'd5;
	localparam logic [3:0] ST_DET    = 4'd6;
	localparam logic [3:0] ST_PREP   = 4'd7;
	localparam logic [3:0] ST_LAUNCH = 4'd8;
	localparam logic [3:0] ST_DIV    = 4'd9;
	localparam logic [3:0] ST_OUT    = 4'd10;

	localparam int DS_BITS = COORD_BITS + 3;   // 4p - sum of corners
	localparam int SQ_BITS = 2 * DS_BITS;
	localparam int D2_BITS = SQ_BITS + 2;
	localparam int DF_BITS = COORD_BITS + 1;   // edge vector component
	localparam int PR_BITS = 2 * DF_BITS;
	localparam int MN_BITS = PR_BITS + 1;      // 2x2 minor
	localparam int LO_BITS = 22;               // low slice of the minor

	logic [3:0]          state_q;
	logic [CNT_BITS-1:0] tet_count_q;
	id_t                 scan_i_q;
	id_t                 last_q;
	id_t                 best_q;
	logic [D2_BITS-1:0]  best_d_q;
	coord_t              p_q [3];

	logic cmd_acc;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tet_count_q <= CNT_BITS'(1);
		end else if (cfg_we) begin
			tet_count_q <= cfg_wdata;
		end
	end

	// search length minus one
	logic [CNT_BITS-1:0] cnt_m1;
	id_t                 last_n;
	always_comb begin
		cnt_m1 = tet_count_q - 1'b1;
		if (tet_count_q == '0) begin
			last_n = '0;
		end else if (tet_count_q > CNT_BITS'(MAX_TETS)) begin
			last_n = ID_BITS'(MAX_TETS - 1);
		end else begin
			last_n = cnt_m1[ID_BITS-1:0];
		end
	end

	// tables: one tet table, four vertex copies so all corners read at once
	logic                vert_we;
	logic                tet_we;
	id_t                 tet_raddr;
	logic [TET_W-1:0]    tet_rdata;
	logic [VERT_W-1:0]   vert_rdata [4];
	id_t                 rd_id [4];
	coord_t              vc [4][3];

	assign vert_we   = cmd_acc && (cmd.func == FUNC_LOAD_VERT);
	assign tet_we    = cmd_acc && (cmd.func == FUNC_LOAD_TET);
	assign tet_raddr = (state_q == ST_FETCH0) ? best_q : scan_i_q;

	ntbw_ram #(.WIDTH(TET_W), .DEPTH(MAX_TETS)) u_tet_ram (
		.clk   (clk),
		.we    (tet_we),
		.waddr (cmd.slot),
		.wdata ({cmd.corner_in_a, cmd.corner_in_b, cmd.corner_in_c, cmd.corner_in_d}),
		.raddr (tet_raddr),
		.rdata (tet_rdata)
	);

	for (genvar j = 0; j < 4; j++) begin : g_vram
		assign rd_id[j] = tet_rdata[(3-j)*ID_BITS +: ID_BITS];
		ntbw_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTS)) u_vert_ram (
			.clk   (clk),
			.we    (vert_we),
			.waddr (cmd.slot),
			.wdata ({cmd.coord_x, cmd.coord_y, cmd.coord_z}),
			.raddr (rd_id[j]),
			.rdata (vert_rdata[j])
		);
		assign vc[j][0] = $signed(vert_rdata[j][VERT_W-1 -: COORD_BITS]);
		assign vc[j][1] = $signed(vert_rdata[j][2*COORD_BITS-1 -: COORD_BITS]);
		assign vc[j][2] = $signed(vert_rdata[j][COORD_BITS-1:0]);
	end

	// ---------------- scan pipeline ----------------
	// s1: tet entry out, s2: corners out, s3: offsets, s4: squares -> compare
	logic                      sv_s1, sv_s2, sv_s3, sv_s4;
	id_t                       idx_s1, idx_s2, idx_s3, idx_s4;
	logic signed [DS_BITS-1:0] cdiff [3];
	logic signed [DS_BITS-1:0] diff_s3 [3];
	logic signed [SQ_BITS-1:0] sq_s4 [3];
	logic [D2_BITS-1:0]        d2;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cdiff[k] = $signed({p_q[k], 2'b00})
				- (vc[0][k] + vc[1][k] + vc[2][k] + vc[3][k]);
		end
		d2 = D2_BITS'(sq_s4[0]) + D2_BITS'(sq_s4[1]) + D2_BITS'(sq_s4[2]);
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_i_q;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		for (int k = 0; k < 3; k++) begin
			diff_s3[k] <= cdiff[k];
			sq_s4[k]   <= diff_s3[k] * diff_s3[k];
		end
	end

	// ---------------- volume pipeline ----------------
	logic [1:0]                det_j_q;
	logic [2:0]                step_q;
	coord_t                    sel_a [3], sel_b [3], sel_c [3], sel_d [3];
	coord_t                    cv_q [4][3];
	id_t                       ids_q [4];
	logic signed [DF_BITS-1:0] du_q [3], dv_q [3], dw_q [3];
	logic signed [DF_BITS-1:0] op_u, op_va, op_wb, op_vb, op_wa;
	logic [1:0]                term_k;
	logic                      issue;
	logic                      mv_s1, mv_s2, mv_s3;
	logic signed [DF_BITS-1:0] ua_s1, ua_s2;
	logic signed [PR_BITS-1:0] prod_a_s1, prod_b_s1;
	logic signed [MN_BITS-1:0] minor_s2;
	logic signed [DF_BITS+LO_BITS:0] lo_s3;
	logic signed [PR_BITS-1:0] hi_s3;
	vol_t                      term;
	vol_t                      acc_q;
	vol_t                      vol_q [4];   // reference volume, then W0..W2
	vol_t                      sub3_q;
	logic                      deg_q;

	// corner order of each volume; the query point closes the sub-volumes
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			unique case (det_j_q)
				2'd0: begin
					sel_a[k] = cv_q[0][k]; sel_b[k] = cv_q[1][k];
					sel_c[k] = cv_q[2][k]; sel_d[k] = cv_q[3][k];
				end
				2'd1: begin
					sel_a[k] = cv_q[1][k]; sel_b[k] = cv_q[3][k];
					sel_c[k] = cv_q[2][k]; sel_d[k] = p_q[k];
				end
				2'd2: begin
					sel_a[k] = cv_q[0][k]; sel_b[k] = cv_q[2][k];
					sel_c[k] = cv_q[3][k]; sel_d[k] = p_q[k];
				end
				2'd3: begin
					sel_a[k] = cv_q[3][k]; sel_b[k] = cv_q[1][k];
					sel_c[k] = cv_q[0][k]; sel_d[k] = p_q[k];
				end
			endcase
		end
	end

	// det3 = sum over k of u[k] * (v[k+1] w[k+2] - v[k+2] w[k+1]), indices mod 3
	assign issue  = (state_q == ST_DET) && (step_q >= 3'd1) && (step_q <= 3'd3);
	assign term_k = 2'(step_q - 3'd1);

	always_comb begin
		case (term_k)
			2'd0: begin
				op_u = du_q[0]; op_va = dv_q[1]; op_wb = dw_q[2];
				op_vb = dv_q[2]; op_wa = dw_q[1];
			end
			2'd1: begin
				op_u = du_q[1]; op_va = dv_q[2]; op_wb = dw_q[0];
				op_vb = dv_q[0]; op_wa = dw_q[2];
			end
			2'd2: begin
				op_u = du_q[2]; op_va = dv_q[0]; op_wb = dw_q[1];
				op_vb = dv_q[1]; op_wa = dw_q[0];
			end
			default: begin
				op_u = '0; op_va = '0; op_wb = '0; op_vb = '0; op_wa = '0;
			end
		endcase
	end

	// minor split so each product stays narrow
	assign term = $signed({hi_s3, {LO_BITS{1'b0}}}) + lo_s3;

	always_ff @(posedge clk) begin
		prod_a_s1 <= op_va * op_wb;
		prod_b_s1 <= op_vb * op_wa;
		ua_s1     <= op_u;
		minor_s2  <= prod_a_s1 - prod_b_s1;
		ua_s2     <= ua_s1;
		lo_s3     <= ua_s2 * $signed({1'b0, minor_s2[LO_BITS-1:0]});
		hi_s3     <= ua_s2 * $signed(minor_s2[MN_BITS-1:LO_BITS]);
	end

	// ---------------- divider row ----------------
	div_link_t link [NUM_CELLS];
	vol_t      numer [NUM_CELLS];
	logic      div_done [NUM_CELLS];
	weight_t   div_w [NUM_CELLS];

	assign link[0].start   = (state_q == ST_LAUNCH);
	assign link[0].divisor = vol_q[0];
	assign numer[0] = vol_q[1];
	assign numer[1] = vol_q[2];
	assign numer[2] = vol_q[3];
	assign numer[3] = sub3_q;

	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		if (c < NUM_CELLS - 1) begin : g_mid
			ntbw_div_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.link_in  (link[c]),
				.numer    (numer[c]),
				.link_out (link[c+1]),
				.done     (div_done[c]),
				.weight   (div_w[c])
			);
		end else begin : g_end
			ntbw_div_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.link_in  (link[c]),
				.numer    (numer[c]),
				.link_out (),
				.done     (div_done[c]),
				.weight   (div_w[c])
			);
		end
	end

	// ---------------- output register ----------------
	logic    rsp_valid_q;
	id_t     rsp_corner_q [4];
	weight_t rsp_weight_q [4];
	logic    rsp_deg_q;
	logic    rsp_load;

	assign rsp_load = (state_q == ST_OUT) && (!rsp_valid_q || rsp.ready);

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_i_q    <= '0;
			sv_s1       <= 1'b0;
			sv_s2       <= 1'b0;
			sv_s3       <= 1'b0;
			sv_s4       <= 1'b0;
			mv_s1       <= 1'b0;
			mv_s2       <= 1'b0;
			mv_s3       <= 1'b0;
			det_j_q     <= '0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			sv_s1 <= (state_q == ST_SCAN);
			sv_s2 <= sv_s1;
			sv_s3 <= sv_s2;
			sv_s4 <= sv_s3;
			mv_s1 <= issue;
			mv_s2 <= mv_s1;
			mv_s3 <= mv_s2;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc && (cmd.func == FUNC_QUERY)) begin
						scan_i_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_i_q <= scan_i_q + 1'b1;
					if (scan_i_q == last_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!(sv_s1 || sv_s2 || sv_s3 || sv_s4)) begin
						state_q <= ST_FETCH0;
					end
				end
				ST_FETCH0: state_q <= ST_FETCH1;
				ST_FETCH1: state_q <= ST_FETCH2;
				ST_FETCH2: begin
					det_j_q <= '0;
					step_q  <= '0;
					state_q <= ST_DET;
				end
				ST_DET: begin
					if (step_q == 3'd7) begin
						step_q  <= '0;
						det_j_q <= det_j_q + 1'b1;
						if (det_j_q == 2'd3) begin
							state_q <= ST_PREP;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_PREP: begin
					state_q <= (vol_q[0] <= 0) ? ST_OUT : ST_LAUNCH;
				end
				ST_LAUNCH: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done[NUM_CELLS-1]) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (cmd_acc && (cmd.func == FUNC_QUERY)) begin
			p_q[0] <= cmd.coord_x;
			p_q[1] <= cmd.coord_y;
			p_q[2] <= cmd.coord_z;
			last_q <= last_n;
		end
		// first entry always wins, later ones only when strictly nearer
		if (sv_s4 && ((idx_s4 == '0) || (d2 < best_d_q))) begin
			best_d_q <= d2;
			best_q   <= idx_s4;
		end
		if (state_q == ST_FETCH1) begin
			for (int j = 0; j < 4; j++) begin
				ids_q[j] <= rd_id[j];
			end
		end
		if (state_q == ST_FETCH2) begin
			for (int j = 0; j < 4; j++) begin
				for (int k = 0; k < 3; k++) begin
					cv_q[j][k] <= vc[j][k];
				end
			end
		end
		if ((state_q == ST_DET) && (step_q == 3'd0)) begin
			for (int k = 0; k < 3; k++) begin
				du_q[k] <= sel_b[k] - sel_a[k];
				dv_q[k] <= sel_c[k] - sel_a[k];
				dw_q[k] <= sel_d[k] - sel_a[k];
			end
			acc_q <= '0;
		end else if (mv_s3) begin
			acc_q <= acc_q + term;
		end
		// volume of [x y z 1] rows is minus det3 of the edge vectors
		if ((state_q == ST_DET) && (step_q == 3'd7)) begin
			vol_q[det_j_q] <= VOL_BITS'(0) - acc_q;
		end
		if (state_q == ST_PREP) begin
			sub3_q <= vol_q[0] - (vol_q[1] + vol_q[2] + vol_q[3]);
			deg_q  <= (vol_q[0] <= 0);
		end
		if (rsp_load) begin
			for (int j = 0; j < 4; j++) begin
				rsp_corner_q[j] <= ids_q[j];
				rsp_weight_q[j] <= deg_q ? '0 : div_w[j];
			end
			rsp_deg_q <= deg_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.corner_a   = rsp_corner_q[0];
	assign rsp.corner_b   = rsp_corner_q[1];
	assign rsp.corner_c   = rsp_corner_q[2];
	assign rsp.corner_d   = rsp_corner_q[3];
	assign rsp.weight_a   = rsp_weight_q[0];
	assign rsp.weight_b   = rsp_weight_q[1];
	assign rsp.weight_c   = rsp_weight_q[2];
	assign rsp.weight_d   = rsp_weight_q[3];
	assign rsp.degenerate = rsp_deg_q;
endmodule

@@ rtl/ntbw_checker.sv @@
`include "nearest_tet_barycentric_weights_assert.svh"

module ntbw_checker import ntbw_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic [1:0] cmd_func,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input id_t        rsp_corner_a,
	input weight_t    rsp_weight_a,
	input weight_t    rsp_weight_b,
	input weight_t    rsp_weight_c,
	input weight_t    rsp_weight_d,
	input logic       rsp_degenerate
);
	`NTBW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	`NTBW_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_weight_a) && $stable(rsp_corner_a) && $stable(rsp_degenerate))
	`NTBW_ASSERT_IMPL(a_deg_zero, rsp_valid && rsp_degenerate, (rsp_weight_a == '0) && (rsp_weight_b == '0) && (rsp_weight_c == '0) && (rsp_weight_d == '0))
	`NTBW_ASSERT_NEXT(a_load_quiet, cmd_valid && cmd_ready && !rsp_valid && (cmd_func != FUNC_QUERY), !rsp_valid)
endmodule

bind nearest_tet_barycentric_weights ntbw_checker u_ntbw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.cmd_func       (cmd.func),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_corner_a   (rsp.corner_a),
	.rsp_weight_a   (rsp.weight_a),
	.rsp_weight_b   (rsp.weight_b),
	.rsp_weight_c   (rsp.weight_c),
	.rsp_weight_d   (rsp.weight_d),
	.rsp_degenerate (rsp.degenerate)
);
